// File: sv/led_strip_effect_generator_assert.svh
// ----------------------------------------------------------------------------
// led strip effect generator assertion macros
// concurrent assertion wrappers, empty when built for synthesis
// ----------------------------------------------------------------------------
`ifndef LED_STRIP_EFFECT_GENERATOR_ASSERT_SVH
`define LED_STRIP_EFFECT_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS

// clocked check, switched off while reset is asserted
`define LSEG_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// clocked check that also holds during reset
`define LSEG_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define LSEG_ASSERT(label, clk, rst_n, prop, msg)
`define LSEG_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// File: sv/lseg_pkg.sv
// ----------------------------------------------------------------------------
// lseg_pkg
// shared widths, codes and types of the led strip effect generator
// ----------------------------------------------------------------------------
package lseg_pkg;

  // field widths
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned COLOR_W   = 24;
  localparam int unsigned PERIOD_W  = 16;
  localparam int unsigned DUTY_W    = 7;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned SPOT_W    = 4;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;

  // serial divider geometry
  localparam int unsigned DIV_NUM_W = 32;
  localparam int unsigned DIV_DEN_W = 16;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_NUM_W);

  // arithmetic constants
  localparam int unsigned PERCENT   = 100;
  localparam int unsigned PULSE_MUL = 510;
  localparam int unsigned BRI_MAX   = 255;

  // register reset values
  localparam logic [MODE_W-1:0]   MODE_RST   = 3'd0;
  localparam logic [COLOR_W-1:0]  COLOR_RST  = 24'h202020;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd500;
  localparam logic [DUTY_W-1:0]   DUTY_RST   = 7'd50;
  localparam logic [TIME_W-1:0]   PHASE_RST  = 32'd0;
  localparam logic [PERIOD_W-1:0] TICK_RST   = 16'd20;

  // effect modes
  typedef enum logic [MODE_W-1:0] {
    MODE_OFF   = 3'd0,
    MODE_SOLID = 3'd1,
    MODE_BLINK = 3'd2,
    MODE_PULSE = 3'd3,
    MODE_WIPE  = 3'd4
  } mode_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 3'd0,
    CFG_COLOR  = 3'd1,
    CFG_PERIOD = 3'd2,
    CFG_DUTY   = 3'd3,
    CFG_PHASE  = 3'd4,
    CFG_TICK   = 3'd5
  } cfg_idx_e;

  // divider request and response
  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] dividend;
    logic [DIV_DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
    logic [DIV_DEN_W-1:0] rem;
  } div_res_t;

  // one result item
  typedef struct packed {
    logic               changed;
    logic [COLOR_W-1:0] fill;
    logic               spot;
    logic [SPOT_W-1:0]  sidx;
    logic [COLOR_W-1:0] scol;
  } res_t;

endpackage

// File: sv/lseg_div.sv
// ----------------------------------------------------------------------------
// lseg_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lseg_div import lseg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_res_t res_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_NUM_W-1:0] num_q, num_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d;
  logic [DIV_DEN_W-1:0] den_q, den_d;
  logic [DIV_DEN_W:0]   trial;
  logic                 fits;

  // partial remainder with the next dividend bit shifted in
  assign trial = {rem_q, num_q[DIV_NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  // step control
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = req_i.dividend;
      rem_d  = '0;
      den_d  = req_i.divisor;
    end else if (busy_q) begin
      num_d = {num_q[DIV_NUM_W-2:0], fits};
      rem_d = fits ? DIV_DEN_W'(trial - {1'b0, den_q}) : trial[DIV_DEN_W-1:0];
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(DIV_NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath shift registers
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign res_o = '{busy: busy_q, done: done_q, quot: num_q, rem: rem_q};

endmodule

// File: sv/led_strip_effect_generator.sv
// ----------------------------------------------------------------------------
// led_strip_effect_generator
// renders off, solid, blink, pulse and wipe effects from millisecond ticks
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+--------------------------
//  in      | input     | in_valid_i / in_ready_o  | now_ms_i
//  out     | output    | out_valid_o / out_ready_i| frame_changed_o, fill_color_o,
//          |           |                          | spot_active_o, spot_index_o,
//          |           |                          | spot_color_o
//  cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
//  a throttled item goes from S_EVAL back to S_IDLE and gives no result; off,
//  solid, unused modes and a zero period go from S_EVAL to S_EMIT and the
//  output register; blink and wipe pass S_DIV1, S_PREP and S_DIV2, pulse also
//  S_SCALE: each runs the 32-step serial divider twice, which sets the rate
//  one item at a time; a new item is taken once the previous one has been
//  handed to the output register, which holds it while out_ready_i is low
//  reset clears control state and configuration registers at once, no clearing pass
//
module led_strip_effect_generator import lseg_pkg::*; #(
  parameter int unsigned PIXEL_COUNT = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [TIME_W-1:0]    now_ms_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 frame_changed_o,
  output logic [COLOR_W-1:0]   fill_color_o,
  output logic                 spot_active_o,
  output logic [SPOT_W-1:0]    spot_index_o,
  output logic [COLOR_W-1:0]   spot_color_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

`include "led_strip_effect_generator_assert.svh"

  localparam int unsigned POS_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam int unsigned WIPE_W = 8;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EVAL  = 7'b0000010,
    S_DIV1  = 7'b0000100,
    S_PREP  = 7'b0001000,
    S_DIV2  = 7'b0010000,
    S_SCALE = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_e;

  // channel scaling c*b/255, exact for 8-bit operands
  function automatic logic [CHAN_W-1:0] scale_ch(input logic [CHAN_W-1:0] c,
                                                 input logic [CHAN_W-1:0] b);
    logic [2*CHAN_W-1:0] p;
    logic [2*CHAN_W:0]   s;
    p = (2*CHAN_W)'(c) * (2*CHAN_W)'(b);
    s = (2*CHAN_W+1)'(p) + (2*CHAN_W+1)'(p[2*CHAN_W-1:CHAN_W]) + (2*CHAN_W+1)'(1);
    return s[2*CHAN_W-1:CHAN_W];
  endfunction

  // configuration registers
  logic [MODE_W-1:0]   mode_q;
  logic [COLOR_W-1:0]  color_q;
  logic [PERIOD_W-1:0] period_q;
  logic [DUTY_W-1:0]   duty_q;
  logic [TIME_W-1:0]   phase_q;
  logic [PERIOD_W-1:0] tick_q;

  // item state
  state_e              state_q, state_d;
  logic [TIME_W-1:0]   now_q;
  logic [TIME_W-1:0]   last_q, last_d;
  logic [POS_W-1:0]    wpos_q, wpos_d;
  logic [PERIOD_W-1:0] cyc_q, cyc_d;
  logic [CHAN_W-1:0]   bri_q, bri_d;
  res_t                res_q, res_d;
  logic                out_valid_q, out_valid_d;
  res_t                out_q;
  logic                out_load;

  // arithmetic around the divider
  logic [TIME_W-1:0]     since_last;
  logic [TIME_W-1:0]     elapsed;
  logic                  throttled;
  logic [PERIOD_W-2:0]   half;
  logic                  cyc_low;
  logic [PERIOD_W-1:0]   diff;
  logic [DIV_NUM_W-1:0]  pulse_num;
  logic [DIV_NUM_W-1:0]  on_prod;
  logic [POS_W-1:0]      pos;
  logic [WIPE_W-1:0]     pos_ext;
  div_req_t              div_req;
  div_res_t              div_res;

  assign since_last = now_q - last_q;
  assign elapsed    = now_q - phase_q;
  assign throttled  = since_last < TIME_W'(tick_q);
  assign half       = period_q[PERIOD_W-1:1];
  assign cyc_low    = cyc_q < {1'b0, half};
  assign diff       = cyc_low ? cyc_q : cyc_q - {1'b0, half};
  assign pulse_num  = DIV_NUM_W'(diff) * DIV_NUM_W'(PULSE_MUL);
  assign on_prod    = DIV_NUM_W'(period_q) * DIV_NUM_W'(duty_q);
  assign pos        = div_res.rem[POS_W-1:0];
  assign pos_ext    = WIPE_W'(pos);

  lseg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    last_d  = last_q;
    wpos_d  = wpos_q;
    cyc_d   = cyc_q;
    bri_d   = bri_q;
    res_d   = res_q;
    div_req = '{start: 1'b0, dividend: elapsed, divisor: period_q};
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EVAL;
      end
      S_EVAL: begin
        if (throttled) begin
          state_d = S_IDLE;
        end else begin
          last_d  = now_q;
          res_d   = '0;
          state_d = S_EMIT;
          unique case (mode_q)
            MODE_OFF:   res_d.changed = 1'b1;
            MODE_SOLID: begin
              res_d.changed = 1'b1;
              res_d.fill    = color_q;
            end
            MODE_BLINK, MODE_PULSE, MODE_WIPE: begin
              if (period_q == '0) begin
                res_d.changed = 1'b1;
              end else begin
                div_req.start = 1'b1;
                state_d       = S_DIV1;
              end
            end
            default: ;
          endcase
        end
      end
      S_DIV1: begin
        if (div_res.done) begin
          cyc_d   = div_res.rem;
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        div_req.start = 1'b1;
        state_d       = S_DIV2;
        unique case (mode_q)
          MODE_BLINK: begin
            div_req.dividend = on_prod;
            div_req.divisor  = DIV_DEN_W'(PERCENT);
          end
          MODE_PULSE: begin
            div_req.dividend = pulse_num;
            div_req.divisor  = period_q;
          end
          default: begin
            div_req.dividend = div_res.quot;
            div_req.divisor  = DIV_DEN_W'(PIXEL_COUNT);
          end
        endcase
      end
      S_DIV2: begin
        if (div_res.done) begin
          state_d = S_EMIT;
          unique case (mode_q)
            MODE_BLINK: begin
              res_d.changed = 1'b1;
              res_d.fill    = (DIV_NUM_W'(cyc_q) < div_res.quot) ? color_q : '0;
            end
            MODE_PULSE: begin
              bri_d   = cyc_low ? div_res.quot[CHAN_W-1:0]
                                : CHAN_W'(BRI_MAX) - div_res.quot[CHAN_W-1:0];
              state_d = S_SCALE;
            end
            default: begin
              res_d.changed = pos != wpos_q;
              wpos_d        = pos;
              res_d.spot    = 1'b1;
              res_d.sidx    = pos_ext[SPOT_W-1:0];
              res_d.scol    = color_q;
            end
          endcase
        end
      end
      S_SCALE: begin
        res_d.changed = 1'b1;
        res_d.fill    = {scale_ch(color_q[23:16], bri_q),
                         scale_ch(color_q[15:8], bri_q),
                         scale_ch(color_q[7:0], bri_q)};
        state_d       = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // output register
  assign out_load    = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);
  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      last_q      <= '0;
      wpos_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      wpos_q      <= wpos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) now_q <= now_ms_i;
    cyc_q <= cyc_d;
    bri_q <= bri_d;
    res_q <= res_d;
    if (out_load) out_q <= res_q;
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_RST;
      color_q  <= COLOR_RST;
      period_q <= PERIOD_RST;
      duty_q   <= DUTY_RST;
      phase_q  <= PHASE_RST;
      tick_q   <= TICK_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MODE:   mode_q   <= cfg_data_i[MODE_W-1:0];
        CFG_COLOR:  color_q  <= cfg_data_i[COLOR_W-1:0];
        CFG_PERIOD: period_q <= cfg_data_i[PERIOD_W-1:0];
        CFG_DUTY:   duty_q   <= cfg_data_i[DUTY_W-1:0];
        CFG_PHASE:  phase_q  <= cfg_data_i[TIME_W-1:0];
        CFG_TICK:   tick_q   <= cfg_data_i[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // ports
  assign in_ready_o      = state_q == S_IDLE;
  assign cfg_ready_o     = 1'b1;
  assign out_valid_o     = out_valid_q;
  assign frame_changed_o = out_q.changed;
  assign fill_color_o    = out_q.fill;
  assign spot_active_o   = out_q.spot;
  assign spot_index_o    = out_q.sidx;
  assign spot_color_o    = out_q.scol;

  // checks
  `LSEG_ASSERT(a_div_start_idle, clk_i, rst_ni, div_req.start |-> !div_res.busy, "divider restarted while busy")
  `LSEG_ASSERT(a_div_done_wait, clk_i, rst_ni, div_res.done |-> (state_q == S_DIV1 || state_q == S_DIV2), "divider result not awaited")
  `LSEG_ASSERT(a_accept_eval, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> (state_q == S_EVAL), "accepted item not evaluated")
  `LSEG_ASSERT(a_wipe_bound, clk_i, rst_ni, 32'(wpos_q) < 32'(PIXEL_COUNT), "wipe position beyond strip")

endmodule

// File: verif/lseg_frame_checker.sv
// ----------------------------------------------------------------------------
// lseg_frame_checker
// watches the item, result and register channels of the led strip effect
// generator, predicts every frame from shadow registers and shadow state,
// and compares each returned frame with the oldest prediction
// ----------------------------------------------------------------------------
module lseg_frame_checker import lseg_pkg::*; #(
  parameter int unsigned PIXEL_COUNT = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [TIME_W-1:0]    now_ms_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic                 frame_changed_i,
  input  logic [COLOR_W-1:0]   fill_color_i,
  input  logic                 spot_active_i,
  input  logic [SPOT_W-1:0]    spot_index_i,
  input  logic [COLOR_W-1:0]   spot_color_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  output int                   mismatch_count_o,
  output int                   pending_o,
  output int                   checked_o,
  output int                   throttled_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_REPORTS = 10;
  localparam logic [31:0] PCT_SCALE  = 32'd100;
  localparam logic [31:0] TRI_GAIN   = 32'd510;
  localparam logic [31:0] FULL_SCALE = 32'd255;

  // shadow copies of the effect registers
  logic [MODE_W-1:0]   mode_q;
  logic [COLOR_W-1:0]  color_q;
  logic [PERIOD_W-1:0] period_q;
  logic [DUTY_W-1:0]   duty_q;
  logic [TIME_W-1:0]   phase_q;
  logic [PERIOD_W-1:0] tick_q;

  // shadow state
  logic [TIME_W-1:0] last_update_q;
  logic [7:0]        wipe_pos_q;

  res_t expected_frames[$];
  int   mismatches = 0;
  int   checked    = 0;
  int   throttled  = 0;

  // scale each channel by brightness / 255, truncating
  function automatic logic [COLOR_W-1:0] dim_color(input logic [COLOR_W-1:0] c,
                                                   input logic [7:0] bri);
    logic [31:0] red, grn, blu;
    red = {24'b0, c[23:16]} * {24'b0, bri} / FULL_SCALE;
    grn = {24'b0, c[15:8]}  * {24'b0, bri} / FULL_SCALE;
    blu = {24'b0, c[7:0]}   * {24'b0, bri} / FULL_SCALE;
    return {red[7:0], grn[7:0], blu[7:0]};
  endfunction

  // frame for one time stamp; returns 0 when the update is throttled
  function automatic logic render_frame(input logic [TIME_W-1:0] stamp,
                                        output res_t frame);
    logic [31:0] since, elapsed, per, cyc, half, bri, pos, on_time;
    frame = '0;
    since = stamp - last_update_q;
    if (since < {16'b0, tick_q}) begin
      return 1'b0;
    end
    last_update_q = stamp;
    elapsed = stamp - phase_q;
    per = {16'b0, period_q};
    case (mode_q)
      MODE_OFF: begin
        frame.changed = 1'b1;
      end
      MODE_SOLID: begin
        frame.changed = 1'b1;
        frame.fill = color_q;
      end
      MODE_BLINK: begin
        frame.changed = 1'b1;
        if (per != 0) begin
          cyc = elapsed % per;
          on_time = per * {25'b0, duty_q} / PCT_SCALE;
          if (cyc < on_time) frame.fill = color_q;
        end
      end
      MODE_PULSE: begin
        frame.changed = 1'b1;
        if (per != 0) begin
          half = per / 2;
          cyc = elapsed % per;
          // rising half then falling half of the triangle
          if (cyc < half) begin
            bri = cyc * TRI_GAIN / per;
          end else begin
            bri = FULL_SCALE - (cyc - half) * TRI_GAIN / per;
          end
          frame.fill = dim_color(color_q, bri[7:0]);
        end
      end
      MODE_WIPE: begin
        if (per == 0) begin
          frame.changed = 1'b1;
        end else begin
          pos = (elapsed / per) % PIXEL_COUNT;
          if (pos[7:0] != wipe_pos_q) begin
            frame.changed = 1'b1;
            wipe_pos_q = pos[7:0];
          end
          frame.spot = 1'b1;
          frame.sidx = wipe_pos_q[SPOT_W-1:0];
          frame.scol = color_q;
        end
      end
      default: begin
      end
    endcase
    return 1'b1;
  endfunction

  // monitor all three channels at each edge
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    res_t frame;
    if (!rst_ni) begin
      mode_q        = MODE_OFF;
      color_q       = 24'h202020;
      period_q      = 16'd500;
      duty_q        = 7'd50;
      phase_q       = '0;
      tick_q        = 16'd20;
      last_update_q = '0;
      wipe_pos_q    = '0;
      expected_frames.delete();
    end else begin
      // returned frame against the oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (expected_frames.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: frame with none predicted: chg=%0b fill=%06h spot=%0b idx=%0d col=%06h",
                     $time, frame_changed_i, fill_color_i, spot_active_i, spot_index_i,
                     spot_color_i);
          end
        end else begin
          frame = expected_frames.pop_front();
          checked++;
          if (frame_changed_i !== frame.changed || fill_color_i !== frame.fill ||
              spot_active_i !== frame.spot || spot_index_i !== frame.sidx ||
              spot_color_i !== frame.scol) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("%0t: frame mismatch, exp chg=%0b fill=%06h spot=%0b idx=%0d col=%06h",
                       $time, frame.changed, frame.fill, frame.spot, frame.sidx, frame.scol);
              $display("%0t:                 got chg=%0b fill=%06h spot=%0b idx=%0d col=%06h",
                       $time, frame_changed_i, fill_color_i, spot_active_i, spot_index_i,
                       spot_color_i);
            end
          end
        end
      end
      // register writes, unknown indexes ignored
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_MODE:   mode_q   = cfg_data_i[MODE_W-1:0];
          CFG_COLOR:  color_q  = cfg_data_i[COLOR_W-1:0];
          CFG_PERIOD: period_q = cfg_data_i[PERIOD_W-1:0];
          CFG_DUTY:   duty_q   = cfg_data_i[DUTY_W-1:0];
          CFG_PHASE:  phase_q  = cfg_data_i[TIME_W-1:0];
          CFG_TICK:   tick_q   = cfg_data_i[PERIOD_W-1:0];
          default: begin
          end
        endcase
      end
      // new time stamp
      if (in_valid_i && in_ready_i) begin
        if (render_frame(now_ms_i, frame)) begin
          expected_frames.push_back(frame);
        end else begin
          throttled++;
        end
      end
    end
    mismatch_count_o <= mismatches;
    pending_o        <= expected_frames.size();
    checked_o        <= checked;
    throttled_o      <= throttled;
  end

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives time stamps and effect settings into the led strip effect generator,
// with random gaps on the sender and random back-pressure on the receiver;
// the frame checker beside the block predicts and compares every frame
// ----------------------------------------------------------------------------
module testbench import lseg_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STAMP_TARGET = 1600;
  localparam int unsigned IDLE_PCT     = 29;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned RESET_CYCLES = 8;
  localparam int unsigned PIXELS       = 16;
  localparam int unsigned STEADY_PHASE = 3;
  localparam int          TIMEOUT_NS   = 8_000_000;

  // unused mode codes and register indexes past the list
  localparam logic [MODE_W-1:0]    MODE_SPARE_LO = 3'd5;
  localparam logic [MODE_W-1:0]    MODE_SPARE_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI  = 3'd7;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [TIME_W-1:0]    now_ms    = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 frame_changed;
  logic [COLOR_W-1:0]   fill_color;
  logic                 spot_active;
  logic [SPOT_W-1:0]    spot_index;
  logic [COLOR_W-1:0]   spot_color;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;

  int mismatch_count;
  int pending;
  int checked;
  int throttled;
  int stamps_sent = 0;
  int settings    = 0;
  bit steady      = 1'b0;

  always #5 clk = ~clk;

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  led_strip_effect_generator #(
    .PIXEL_COUNT(PIXELS)
  ) i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .now_ms_i       (now_ms),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .frame_changed_o(frame_changed),
    .fill_color_o   (fill_color),
    .spot_active_o  (spot_active),
    .spot_index_o   (spot_index),
    .spot_color_o   (spot_color),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  lseg_frame_checker #(
    .PIXEL_COUNT(PIXELS)
  ) i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .now_ms_i        (now_ms),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .frame_changed_i (frame_changed),
    .fill_color_i    (fill_color),
    .spot_active_i   (spot_active),
    .spot_index_i    (spot_index),
    .spot_color_i    (spot_color),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending),
    .checked_o       (checked),
    .throttled_o     (throttled)
  );

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("TB_ERROR");
    $finish;
  end

  // one time stamp item, with an optional gap in front
  task automatic put_stamp(input logic [TIME_W-1:0] stamp);
    if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    now_ms   <= stamp;
    do @(posedge clk); while (!in_ready);
    stamps_sent++;
  endtask

  // one register write, valid left high for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // hold items back until every predicted frame is out and the block is idle
  task automatic quiesce();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // new effect setting, upper data bits random to exercise masking
  task automatic program_effect(input logic [MODE_W-1:0] mode, input logic [COLOR_W-1:0] color,
                                input logic [PERIOD_W-1:0] period,
                                input logic [DUTY_W-1:0] duty, input logic [TIME_W-1:0] phase,
                                input logic [PERIOD_W-1:0] tick);
    logic [CFG_DAT_W-1:0] d;
    quiesce();
    d = $urandom(); d[MODE_W-1:0]   = mode;   write_reg(CFG_MODE, d);
    d = $urandom(); d[COLOR_W-1:0]  = color;  write_reg(CFG_COLOR, d);
    d = $urandom(); d[PERIOD_W-1:0] = period; write_reg(CFG_PERIOD, d);
    d = $urandom(); d[DUTY_W-1:0]   = duty;   write_reg(CFG_DUTY, d);
    write_reg(CFG_PHASE, phase);
    d = $urandom(); d[PERIOD_W-1:0] = tick;   write_reg(CFG_TICK, d);
    if ($urandom_range(0, 4) == 0) begin
      write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, $urandom());
    end
    cfg_valid <= 1'b0;
    settings++;
  endtask

  initial begin : stimulus
    logic [TIME_W-1:0]    tnow;
    logic [MODE_W-1:0]    mode;
    logic [COLOR_W-1:0]   color;
    logic [DUTY_W-1:0]    duty;
    logic [TIME_W-1:0]    phase;
    int unsigned          period;
    int unsigned          tick;
    int unsigned          sel;
    int unsigned          len;
    int unsigned          phase_no;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: throttle window and off
    put_stamp(32'd0);
    put_stamp(32'd20);
    put_stamp(32'd39);

    // solid, time wrapping with no throttle
    program_effect(MODE_SOLID, 24'hFFFFFF, 16'd500, 7'd50, 32'd0, 16'd0);
    put_stamp(32'hFFFFFFFF);
    put_stamp(32'd0);

    // blink across the on and off edges, phase start near the wrap
    program_effect(MODE_BLINK, 24'h123456, 16'd1000, 7'd50, 32'hFFFFFF00, 16'd1);
    put_stamp(32'hFFFFFF00);
    put_stamp(32'hFFFFFF00 + 32'd499);
    put_stamp(32'hFFFFFF00 + 32'd500);
    put_stamp(32'hFFFFFF00 + 32'd999);

    // duty above one hundred stays on, zero duty stays off
    program_effect(MODE_BLINK, 24'hA5A5A5, 16'd100, 7'd127, 32'd0, 16'd0);
    put_stamp(32'd99);
    program_effect(MODE_BLINK, 24'h5A5A5A, 16'd100, 7'd0, 32'd0, 16'd0);
    put_stamp(32'd5);

    // pulse at the longest period: bottom, near peak, peak, near bottom
    program_effect(MODE_PULSE, 24'hFFFFFF, 16'hFFFF, 7'd50, 32'd0, 16'd0);
    put_stamp(32'd0);
    put_stamp(32'd32766);
    put_stamp(32'd32767);
    put_stamp(32'd65534);

    // pulse with period one, then zero period clears the strip
    program_effect(MODE_PULSE, 24'h80FF01, 16'd1, 7'd50, 32'd0, 16'd0);
    put_stamp(32'd7);
    program_effect(MODE_PULSE, 24'h80FF01, 16'd0, 7'd50, 32'd0, 16'd0);
    put_stamp(32'd8);

    // wipe: standing, moving, standing, last pixel, back to the first
    program_effect(MODE_WIPE, 24'h00FF00, 16'd10, 7'd50, 32'd0, 16'd0);
    put_stamp(32'd0);
    put_stamp(32'd10);
    put_stamp(32'd15);
    put_stamp(32'd159);
    put_stamp(32'd160);
    program_effect(MODE_WIPE, 24'h00FF00, 16'd0, 7'd50, 32'd0, 16'd0);
    put_stamp(32'd200);

    // unused modes and writes past the register list
    program_effect(MODE_SPARE_LO, 24'hFFFFFF, 16'd10, 7'd50, 32'd0, 16'd0);
    @(posedge clk);
    write_reg(CFG_SPARE_LO, $urandom());
    write_reg(CFG_SPARE_HI, $urandom());
    cfg_valid <= 1'b0;
    put_stamp(32'd300);
    program_effect(MODE_SPARE_HI, 24'hFFFFFF, 16'd10, 7'd50, 32'd0, 16'd0);
    put_stamp(32'd301);

    // random settings, each followed by a run of time stamps
    tnow = 32'd400;
    phase_no = 0;
    while (stamps_sent < STAMP_TARGET) begin
      mode = ($urandom_range(0, 9) == 0) ? MODE_W'($urandom_range(5, 7))
                                         : MODE_W'($urandom_range(0, 4));
      sel = $urandom_range(0, 99);
      color = (sel < 10) ? 24'h000000 : (sel < 20) ? 24'hFFFFFF : COLOR_W'($urandom());
      sel = $urandom_range(0, 99);
      if (sel < 8)       period = 0;
      else if (sel < 13) period = 1;
      else if (sel < 18) period = 16'hFFFF;
      else if (sel < 68) period = $urandom_range(2, 200);
      else               period = $urandom_range(0, 16'hFFFF);
      sel = $urandom_range(0, 99);
      duty = (sel < 10) ? 7'd0 : (sel < 20) ? 7'd100 : (sel < 30) ? 7'd127
                        : DUTY_W'($urandom_range(0, 127));
      phase = $urandom_range(0, 1) ? TIME_W'($urandom()) : tnow - $urandom_range(0, 1000);
      sel = $urandom_range(0, 99);
      if (sel < 10)      tick = 0;
      else if (sel < 13) tick = 16'hFFFF;
      else if (sel < 73) tick = $urandom_range(0, 40);
      else               tick = $urandom_range(0, 16'hFFFF);
      program_effect(mode, color, PERIOD_W'(period), duty, phase, PERIOD_W'(tick));

      // one long stretch with no idling on either side
      steady = (phase_no == STEADY_PHASE);
      len = steady ? 150 : $urandom_range(15, 60);
      repeat (len) begin
        sel = $urandom_range(0, 99);
        if (sel < 55)      tnow = tnow + $urandom_range(0, 2 * tick + 2);
        else if (sel < 80) tnow = tnow + tick + $urandom_range(0, period);
        else if (sel < 95) tnow = tnow + $urandom_range(0, 3);
        else               tnow = $urandom();
        put_stamp(tnow);
      end
      steady = 1'b0;
      phase_no++;
    end

    quiesce();
    $display("covered %0d time stamps over %0d effect settings", stamps_sent, settings);
    $display("%0d frames compared, %0d updates throttled", checked, throttled);
    if (mismatch_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
